// ===== src/ppm_pkg.sv =====
// Shared types and constants for the perspective point map.
// Used by every module of the block and by its checker; depends on nothing.
package ppm_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COEF_FRAC_DEF  = 24;
  localparam int COEF_W         = 48;
  localparam int IN_W           = 12;
  localparam int OUT_W          = 28;
  localparam int OUT_FRAC       = 8;
  localparam int NUM_REGS       = 8;
  localparam int IDX_W          = 3;
  // Input register, product, sum, three divider setup stages, one stage
  // per quotient bit, and the output stage.
  localparam int PIPE_LAT       = 6 + OUT_W + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_XX       = 3'd0,
    REG_COEF_XY       = 3'd1,
    REG_COEF_X_OFFSET = 3'd2,
    REG_COEF_YX       = 3'd3,
    REG_COEF_YY       = 3'd4,
    REG_COEF_Y_OFFSET = 3'd5,
    REG_PERSP_X       = 3'd6,
    REG_PERSP_Y       = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MAP_OK       = 2'd0,
    MAP_SAT      = 2'd1,
    MAP_DEN_ZERO = 2'd2
  } map_status_e;

  typedef struct packed {
    logic [IN_W-1:0] x_in;
    logic [IN_W-1:0] y_in;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x_out;
    logic signed [OUT_W-1:0] y_out;
    logic [1:0]              map_status;
  } out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] coef_x_offset;
    logic signed [COEF_W-1:0] coef_yx;
    logic signed [COEF_W-1:0] coef_yy;
    logic signed [COEF_W-1:0] coef_y_offset;
    logic signed [COEF_W-1:0] persp_x;
    logic signed [COEF_W-1:0] persp_y;
  } coef_set_t;

endpackage

// ===== src/ppm_front.sv =====
// Front end: input register, coefficient products and the three sums.
// Depends on ppm_pkg for the item and coefficient types.
module ppm_front #(
  parameter int COORD_BITS     = ppm_pkg::COORD_BITS_DEF,
  parameter int COEF_FRAC_BITS = ppm_pkg::COEF_FRAC_DEF,
  parameter int NW             = ppm_pkg::COEF_W + COORD_BITS + 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  ppm_pkg::in_t             item_i,
  input  ppm_pkg::coef_set_t       coef_i,
  output logic                     valid_o,
  output logic signed [NW-1:0]     num_x_o,
  output logic signed [NW-1:0]     num_y_o,
  output logic signed [NW-1:0]     den_o
);

  localparam int PW = ppm_pkg::COEF_W + COORD_BITS + 1;

  logic                  v1_q, v2_q, v3_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic signed [PW-1:0]  p_xx_q, p_xy_q, p_yx_q, p_yy_q, p_px_q, p_py_q;
  logic signed [PW-1:0]  p_xx_d, p_xy_d, p_yx_d, p_yy_d, p_px_d, p_py_d;
  logic signed [ppm_pkg::COEF_W-1:0] off_x_q, off_y_q;
  logic signed [NW-1:0]  nx_q, ny_q, den_q;
  logic signed [COORD_BITS:0] xs, ys;

  assign xs = $signed({1'b0, x_q});
  assign ys = $signed({1'b0, y_q});

  always_comb begin
    p_xx_d = PW'(coef_i.coef_xx * xs);
    p_xy_d = PW'(coef_i.coef_xy * ys);
    p_yx_d = PW'(coef_i.coef_yx * xs);
    p_yy_d = PW'(coef_i.coef_yy * ys);
    p_px_d = PW'(coef_i.persp_x * xs);
    p_py_d = PW'(coef_i.persp_y * ys);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= COORD_BITS'(item_i.x_in);
    y_q     <= COORD_BITS'(item_i.y_in);
    p_xx_q  <= p_xx_d;
    p_xy_q  <= p_xy_d;
    p_yx_q  <= p_yx_d;
    p_yy_q  <= p_yy_d;
    p_px_q  <= p_px_d;
    p_py_q  <= p_py_d;
    off_x_q <= coef_i.coef_x_offset;
    off_y_q <= coef_i.coef_y_offset;
    nx_q    <= NW'(p_xx_q) + NW'(p_xy_q) + NW'(off_x_q);
    ny_q    <= NW'(p_yx_q) + NW'(p_yy_q) + NW'(off_y_q);
    den_q   <= NW'(p_px_q) + NW'(p_py_q) + $signed(NW'(64'd1 << COEF_FRAC_BITS));
  end

  assign valid_o = v3_q;
  assign num_x_o = nx_q;
  assign num_y_o = ny_q;
  assign den_o   = den_q;

endmodule

// ===== src/ppm_div.sv =====
// Pipelined rounding divider for one coordinate: one quotient bit per stage.
// Depends on ppm_pkg for the output width and fraction bits.
module ppm_div #(
  parameter int NW = ppm_pkg::COEF_W + ppm_pkg::COORD_BITS_DEF + 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [NW-1:0]              num_i,
  input  logic signed [NW-1:0]              den_i,
  output logic                              valid_o,
  output logic signed [ppm_pkg::OUT_W-1:0]  res_o,
  output logic                              sat_o,
  output logic                              zero_o
);

  localparam int QB = ppm_pkg::OUT_W;
  localparam int RW = NW + QB;

  // Setup stages: magnitudes, then rounded dividend, then range check.
  logic          va_q, vb_q, vc_q;
  logic [NW-1:0] an_q, ad_q, dv_b_q;
  logic [RW-1:0] nb_q;
  logic          neg_a_q, neg_b_q, zero_a_q, zero_b_q;

  logic [RW-1:0] rem_q  [QB+1];
  logic [NW-1:0] dv_q   [QB+1];
  logic [QB-1:0] quo_q  [QB+1];
  logic          neg_q  [QB+1];
  logic          ovf_q  [QB+1];
  logic          zero_q [QB+1];
  logic          v_q    [QB+1];

  logic          vo_q, sat_q, zo_q;
  logic [QB-1:0] lim, mag;
  logic signed [QB-1:0] res_q;
  logic          over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q     <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    ad_q     <= den_i[NW-1] ? NW'(-den_i) : NW'(den_i);
    neg_a_q  <= num_i[NW-1] ^ den_i[NW-1];
    zero_a_q <= (den_i == '0);
    // Adding the divisor before halving gives round half away from zero.
    nb_q     <= (RW'(an_q) << (ppm_pkg::OUT_FRAC + 1)) + RW'(ad_q);
    dv_b_q   <= NW'({ad_q, 1'b0});
    neg_b_q  <= neg_a_q;
    zero_b_q <= zero_a_q;
  end

  assign vc_q = vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= nb_q;
    dv_q[0]   <= dv_b_q;
    quo_q[0]  <= '0;
    neg_q[0]  <= neg_b_q;
    ovf_q[0]  <= nb_q >= (RW'(dv_b_q) << QB);
    zero_q[0] <= zero_b_q;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int SH = QB - 1 - k;
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(dv_q[k]) << SH;
    assign ge    = rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= ge ? rem_q[k] - trial : rem_q[k];
      quo_q[k+1]  <= quo_q[k] | (QB'(ge) << SH);
      dv_q[k+1]   <= dv_q[k];
      neg_q[k+1]  <= neg_q[k];
      ovf_q[k+1]  <= ovf_q[k];
      zero_q[k+1] <= zero_q[k];
    end
  end

  always_comb begin
    lim  = neg_q[QB] ? (QB'(1) << (QB - 1)) : ((QB'(1) << (QB - 1)) - QB'(1));
    over = ovf_q[QB] || (quo_q[QB] > lim);
    mag  = over ? lim : quo_q[QB];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= neg_q[QB] ? $signed(QB'(-mag)) : $signed(mag);
    sat_q <= over;
    zo_q  <= zero_q[QB];
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;
  assign sat_o   = sat_q;
  assign zero_o  = zo_q;

endmodule

// ===== src/perspective_point_map.sv =====
// Perspective point map: projective transform of one pixel coordinate.
// The divider resolves one quotient bit per pipeline stage. Throughput
// is one item per cycle; busy stays low and the result receiver cannot
// stall. Reset clears all pipeline valid bits and loads the identity
// transform into the coefficient registers.
module perspective_point_map #(
  parameter int COORD_BITS     = ppm_pkg::COORD_BITS_DEF,
  parameter int COEF_FRAC_BITS = ppm_pkg::COEF_FRAC_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ppm_pkg::in_t                 item_i,
  output logic                         done_o,
  output ppm_pkg::out_t                result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ppm_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [ppm_pkg::COEF_W-1:0]   cfg_data_i
);

  localparam int NW = ppm_pkg::COEF_W + COORD_BITS + 3;
  localparam logic [ppm_pkg::COEF_W-1:0] ONE =
    ppm_pkg::COEF_W'(64'd1 << COEF_FRAC_BITS);

  ppm_pkg::coef_set_t coef_q;
  logic               fv;
  logic signed [NW-1:0] nx, ny, den;
  logic               vx, vy, sx, sy, zx, zy;
  logic signed [ppm_pkg::OUT_W-1:0] rx, ry;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{coef_xx: ONE, coef_yy: ONE, default: '0};
    end else if (cfg_valid_i) begin
      case (ppm_pkg::reg_idx_e'(cfg_index_i))
        ppm_pkg::REG_COEF_XX:       coef_q.coef_xx       <= cfg_data_i;
        ppm_pkg::REG_COEF_XY:       coef_q.coef_xy       <= cfg_data_i;
        ppm_pkg::REG_COEF_X_OFFSET: coef_q.coef_x_offset <= cfg_data_i;
        ppm_pkg::REG_COEF_YX:       coef_q.coef_yx       <= cfg_data_i;
        ppm_pkg::REG_COEF_YY:       coef_q.coef_yy       <= cfg_data_i;
        ppm_pkg::REG_COEF_Y_OFFSET: coef_q.coef_y_offset <= cfg_data_i;
        ppm_pkg::REG_PERSP_X:       coef_q.persp_x       <= cfg_data_i;
        ppm_pkg::REG_PERSP_Y:       coef_q.persp_y       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ppm_front #(
    .COORD_BITS     (COORD_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .NW             (NW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item_i),
    .coef_i  (coef_q),
    .valid_o (fv),
    .num_x_o (nx),
    .num_y_o (ny),
    .den_o   (den)
  );

  ppm_div #(.NW(NW)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv),
    .num_i   (nx),
    .den_i   (den),
    .valid_o (vx),
    .res_o   (rx),
    .sat_o   (sx),
    .zero_o  (zx)
  );

  ppm_div #(.NW(NW)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv),
    .num_i   (ny),
    .den_i   (den),
    .valid_o (vy),
    .res_o   (ry),
    .sat_o   (sy),
    .zero_o  (zy)
  );

  // Both lanes see the same divisor and run in lockstep, so their valid and
  // zero flags always agree.
  always_comb begin
    done_o = vx && vy;
    if (zx || zy) begin
      result_o.x_out      = '0;
      result_o.y_out      = '0;
      result_o.map_status = ppm_pkg::MAP_DEN_ZERO;
    end else begin
      result_o.x_out      = rx;
      result_o.y_out      = ry;
      result_o.map_status = (sx || sy) ? ppm_pkg::MAP_SAT : ppm_pkg::MAP_OK;
    end
  end

endmodule

// ===== src/ppm_checker.sv =====
// Port-level checker for the perspective point map, bound to the top level.
// Depends on ppm_pkg for status codes and output width.
module ppm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          busy,
  input logic          cfg_ready_o,
  input logic          done_o,
  input ppm_pkg::out_t result_o
);

  localparam logic signed [ppm_pkg::OUT_W-1:0] PMAX = {1'b0, {(ppm_pkg::OUT_W-1){1'b1}}};
  localparam logic signed [ppm_pkg::OUT_W-1:0] NMAX = {1'b1, {(ppm_pkg::OUT_W-1){1'b0}}};

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o) else $error("block stalled a channel");

  a_zero_den_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.map_status == ppm_pkg::MAP_DEN_ZERO |->
      result_o.x_out == '0 && result_o.y_out == '0)
    else $error("zero denominator beat carries nonzero coordinates");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.map_status == ppm_pkg::MAP_OK ||
      result_o.map_status == ppm_pkg::MAP_SAT ||
      result_o.map_status == ppm_pkg::MAP_DEN_ZERO) else $error("bad status code");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.map_status == ppm_pkg::MAP_SAT |->
      result_o.x_out == PMAX || result_o.x_out == NMAX ||
      result_o.y_out == PMAX || result_o.y_out == NMAX)
    else $error("saturated beat has no coordinate at a bound");

endmodule

bind perspective_point_map ppm_checker u_ppm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .cfg_ready_o (cfg_ready_o),
  .done_o      (done_o),
  .result_o    (result_o)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for perspective_point_map: drives coordinates and
// coefficient writes, predicts every mapped point and compares. Needs ppm_pkg.
module tb;
  import ppm_pkg::*;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] UNITY    = 48'sd1 << COEF_FRAC_DEF;

  class point_map_board;
    logic signed [COEF_W-1:0] coef[NUM_REGS];
    out_t mapped_q[$];
    int   errors;
    int   reported;

    function new();
      foreach (coef[i]) coef[i] = '0;
      coef[REG_COEF_XX] = UNITY;
      coef[REG_COEF_YY] = UNITY;
      errors   = 0;
      reported = 0;
    endfunction

    function void set_coef(reg_idx_e idx, logic [COEF_W-1:0] val);
      coef[idx] = val;
    endfunction

    // One rounded, saturated quotient with OUT_FRAC fraction bits.
    function logic [OUT_W-1:0] divide_round(logic signed [127:0] num,
                                            logic signed [127:0] den,
                                            inout bit clamped);
      logic [127:0] an, ad, q, lim;
      bit neg;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      q   = ((an << (OUT_FRAC + 1)) + ad) / (ad << 1);
      lim = neg ? (128'd1 << (OUT_W - 1)) : ((128'd1 << (OUT_W - 1)) - 1);
      if (q > lim) begin
        clamped = 1'b1;
        q = lim;
      end
      return neg ? OUT_W'(-q) : OUT_W'(q);
    endfunction

    function void note_point(in_t pt);
      logic signed [127:0] x, y, nx, ny, den;
      out_t exp_res;
      bit clamped;
      x   = pt.x_in;
      y   = pt.y_in;
      nx  = coef[REG_COEF_XX] * x + coef[REG_COEF_XY] * y + coef[REG_COEF_X_OFFSET];
      ny  = coef[REG_COEF_YX] * x + coef[REG_COEF_YY] * y + coef[REG_COEF_Y_OFFSET];
      den = coef[REG_PERSP_X] * x + coef[REG_PERSP_Y] * y + UNITY;
      clamped = 1'b0;
      if (den == 0) begin
        exp_res.x_out = '0;
        exp_res.y_out = '0;
        exp_res.map_status = MAP_DEN_ZERO;
      end else begin
        exp_res.x_out = divide_round(nx, den, clamped);
        exp_res.y_out = divide_round(ny, den, clamped);
        exp_res.map_status = clamped ? MAP_SAT : MAP_OK;
      end
      mapped_q.push_back(exp_res);
    endfunction

    function void check_point(out_t act);
      out_t exp_res;
      if (mapped_q.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result beat: x %0d y %0d status %0d",
                   act.x_out, act.y_out, act.map_status);
        end
        return;
      end
      exp_res = mapped_q.pop_front();
      if (act.x_out !== exp_res.x_out || act.y_out !== exp_res.y_out ||
          act.map_status !== exp_res.map_status) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: expected x %0d y %0d status %0d, got x %0d y %0d status %0d",
                   exp_res.x_out, exp_res.y_out, exp_res.map_status,
                   act.x_out, act.y_out, act.map_status);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  item_i = '0;
  logic done_o;
  out_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;

  point_map_board board = new();

  perspective_point_map i_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_point(result_o);
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_point(in_t pt, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= pt;
    do @(posedge clk_i); while (busy);
    board.note_point(pt);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Coefficients may only change once the pipeline has drained.
  task automatic drain();
    while (board.mapped_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  task automatic write_coef(reg_idx_e idx, logic [COEF_W-1:0] val);
    repeat (pick_gap()) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_coef(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_set(logic [COEF_W-1:0] c[NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) write_coef(reg_idx_e'(i), c[i]);
  endtask

  function automatic logic [COEF_W-1:0] rand_span(int bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    r = r >> (64 - bits);
    return $urandom_range(0, 1) ? COEF_W'(-$signed({1'b0, r})) : COEF_W'(r);
  endfunction

  task automatic send_corners();
    send_point('{x_in: '0, y_in: '0}, 0);
    send_point('{x_in: '1, y_in: '1}, 0);
    send_point('{x_in: '1, y_in: '0}, 1);
    send_point('{x_in: '0, y_in: '1}, 0);
    end_burst();
  endtask

  initial begin
    logic [COEF_W-1:0] cs[NUM_REGS];
    in_t pt;
    int kind, shift, wait_cnt;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Identity transform from reset.
    send_corners();
    drain();

    // Largest positive coefficients, then largest negative ones.
    foreach (cs[i]) cs[i] = COEF_MAX;
    load_set(cs);
    send_corners();
    drain();
    foreach (cs[i]) cs[i] = COEF_MIN;
    load_set(cs);
    send_corners();
    drain();

    // Denominator vanishes at x = 1 and at y = 2.
    foreach (cs[i]) cs[i] = rand_span(40);
    cs[REG_PERSP_X] = -UNITY;
    cs[REG_PERSP_Y] = -(UNITY >>> 1);
    load_set(cs);
    send_point('{x_in: 12'd1, y_in: 12'd0}, 0);
    send_point('{x_in: 12'd0, y_in: 12'd2}, 0);
    send_point('{x_in: 12'd3, y_in: 12'd0}, 0);
    send_point('{x_in: 12'd0, y_in: 12'd0}, 2);
    end_burst();
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      kind  = $urandom_range(0, 3);
      shift = $urandom_range(0, 11);
      case (kind)
        0: begin
          foreach (cs[i]) cs[i] = rand_span(48);
        end
        1: begin
          // Mild keystone: near-unity scale, pixel offsets, tiny perspective.
          cs[REG_COEF_XX]       = UNITY + rand_span(22);
          cs[REG_COEF_XY]       = rand_span(22);
          cs[REG_COEF_X_OFFSET] = rand_span(34);
          cs[REG_COEF_YX]       = rand_span(22);
          cs[REG_COEF_YY]       = UNITY + rand_span(22);
          cs[REG_COEF_Y_OFFSET] = rand_span(34);
          cs[REG_PERSP_X]       = rand_span(12);
          cs[REG_PERSP_Y]       = rand_span(12);
        end
        2: begin
          // Denominator crosses zero at x equal to a power of two.
          foreach (cs[i]) cs[i] = rand_span(36);
          cs[REG_PERSP_X] = -(UNITY >>> shift);
          cs[REG_PERSP_Y] = $urandom_range(0, 1) ? '0 : rand_span(14);
        end
        default: begin
          foreach (cs[i]) cs[i] = rand_span($urandom_range(1, 47));
        end
      endcase
      load_set(cs);
      for (int n = 0; n < 150; n++) begin
        pt.x_in = $urandom;
        pt.y_in = $urandom;
        if (kind == 2 && $urandom_range(0, 2) == 0) begin
          pt.x_in = 12'd1 << shift;
          if ($urandom_range(0, 1)) pt.y_in = '0;
        end
        send_point(pt, (ph % 4 == 3) ? 0 : pick_gap());
      end
      end_burst();
      drain();
    end

    wait_cnt = 0;
    while (board.mapped_q.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (PIPE_LAT + 5) @(posedge clk_i);
    if (board.errors == 0 && board.mapped_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/ppm_pkg.sv
src/ppm_front.sv
src/ppm_div.sv
src/perspective_point_map.sv
src/ppm_checker.sv
tb/sv/tb.sv
